[hdl/tk_pkg.sv]
// ----------------------------------------------------------------------------
// tk_pkg
// Types, constants and the ordering function of the top-k sorted list.
// ----------------------------------------------------------------------------
package tk_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam logic [3:0] BUDGET_RST = 4'd8;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_OFFER = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;

  localparam logic signed [15:0] FALL_MAX = 16'sd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_RD,
    ST_INS_CMP,
    ST_OUT_RD,
    ST_OUT_WR
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic               enabled;
    logic               shader_valid;
    logic signed [15:0] priority_req;
    logic [31:0]        shader_id;
    logic [31:0]        entity_id;
    logic signed [15:0] radius;
    logic signed [15:0] inner_radius;
    logic signed [15:0] falloff;
    logic signed [15:0] strength;
    logic signed [15:0] spin;
    logic [1:0]         shape;
  } cand_t;

  typedef struct packed {
    logic               entry_valid;
    logic               last;
    logic signed [15:0] out_priority;
    logic [31:0]        out_shader_id;
    logic [31:0]        out_entity_id;
    logic [14:0]        out_radius;
    logic [14:0]        out_inner_radius;
    logic [14:0]        out_falloff;
    logic [14:0]        out_strength;
    logic signed [15:0] out_spin;
    logic [1:0]         out_shape;
    logic [3:0]         list_count;
  } res_t;

  typedef struct packed {
    logic [15:0] prio_b;
    logic [31:0] shader;
    logic [31:0] entity;
    logic [14:0] rad;
    logic [14:0] inner;
    logic [14:0] fall;
    logic [14:0] str;
    logic [15:0] spin;
    logic [1:0]  shape;
  } entry_t;

  // true if a sorts strictly before b
  function automatic logic ahead_of(entry_t a, entry_t b);
    return {a.prio_b, a.shader, a.entity} < {b.prio_b, b.shader, b.entity};
  endfunction

endpackage

[hdl/tk_stream_if.sv]
// ----------------------------------------------------------------------------
// tk_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface tk_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/bounded_top_k_sorted_insert.sv]
// ----------------------------------------------------------------------------
// bounded_top_k_sorted_insert
// Ascending list of clamped candidates, filled up to min(budget, CAPACITY).
// ----------------------------------------------------------------------------
// cand_i takes one item per action: clear, offer or read out. res_o gives
// one item per list entry on read out, ascending, last set on the final
// one; an empty list gives a single item with entry_valid low and last set.
// The list lives in one single-port-read memory with a registered read;
// every list step is a read followed by a compare and write back.
// Clear empties the list. An offer ends when rejected outright or when it
// loses to the lowest entry of a full list; otherwise the lowest entry of a
// full list is first evicted by shifting the rest down, and the offer then
// walks down from the top to find its place. Read out gives one entry at a
// time and waits while res_o is stalled; an empty list gives its single
// item directly. Budget is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while the block is idle, the block does not enforce it.
// Reset empties the list and sets the budget to 8; memory contents are not
// cleared, only entries below the count are ever read.
// A stalled res_o holds its item; read out waits for the output register,
// and a read out action is not taken while a result is still waiting.
// ----------------------------------------------------------------------------
module bounded_top_k_sorted_insert #(
  parameter int CAPACITY = tk_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  tk_stream_if.sink   cand_i,
  tk_stream_if.source res_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  tk_pkg::entry_t mem [CAPACITY];
  tk_pkg::entry_t rd_data_q, cand_q, cand_d, wr_data;
  logic           rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;

  tk_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d, idx_q, idx_d, limit;
  logic [3:0]     budget_q;
  tk_pkg::res_t   res_q, res_d;
  logic           res_valid_q, res_valid_d;
  logic           out_free, in_acc, cand_ok;
  tk_pkg::cand_t  c;

  assign c        = cand_i.data;
  assign out_free = !res_valid_q || res_o.ready;
  assign cand_i.ready = (state_q == tk_pkg::ST_IDLE) &&
                        (c.action != tk_pkg::ACT_READ || out_free);
  assign in_acc   = cand_i.valid && cand_i.ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  assign limit = (32'(budget_q) > CAPACITY) ? CntW'(CAPACITY) : CntW'(budget_q);
  assign cand_ok = c.enabled && c.shader_valid && (limit != '0) && (c.radius > 16'sd0);

  always_comb begin
    cand_d.prio_b = c.priority_req ^ 16'h8000;
    cand_d.shader = c.shader_id;
    cand_d.entity = c.entity_id;
    cand_d.rad    = c.radius[14:0];
    if (c.inner_radius < 16'sd0) cand_d.inner = '0;
    else if (c.inner_radius > c.radius) cand_d.inner = c.radius[14:0];
    else cand_d.inner = c.inner_radius[14:0];
    if (c.falloff < 16'sd0) cand_d.fall = '0;
    else if (c.falloff > tk_pkg::FALL_MAX) cand_d.fall = tk_pkg::FALL_MAX[14:0];
    else cand_d.fall = c.falloff[14:0];
    cand_d.str   = (c.strength < 16'sd0) ? 15'd0 : c.strength[14:0];
    cand_d.spin  = c.spin;
    cand_d.shape = c.shape;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tk_pkg::ST_IDLE: begin
        if (in_acc && c.action == tk_pkg::ACT_OFFER && cand_ok)
          state_d = (count_q >= limit) ? tk_pkg::ST_EV_CMP : tk_pkg::ST_INS_RD;
        else if (in_acc && c.action == tk_pkg::ACT_READ && count_q != '0)
          state_d = tk_pkg::ST_OUT_RD;
      end
      tk_pkg::ST_EV_CMP:
        state_d = tk_pkg::ahead_of(rd_data_q, cand_q) ? tk_pkg::ST_SH_RD : tk_pkg::ST_IDLE;
      tk_pkg::ST_SH_RD:
        state_d = (idx_q < count_q) ? tk_pkg::ST_SH_WR : tk_pkg::ST_INS_RD;
      tk_pkg::ST_SH_WR:  state_d = tk_pkg::ST_SH_RD;
      tk_pkg::ST_INS_RD:
        state_d = (idx_q == '0) ? tk_pkg::ST_IDLE : tk_pkg::ST_INS_CMP;
      tk_pkg::ST_INS_CMP:
        state_d = tk_pkg::ahead_of(rd_data_q, cand_q) ? tk_pkg::ST_IDLE : tk_pkg::ST_INS_RD;
      tk_pkg::ST_OUT_RD:
        state_d = out_free ? tk_pkg::ST_OUT_WR : tk_pkg::ST_OUT_RD;
      tk_pkg::ST_OUT_WR:
        state_d = (idx_q + 1'b1 == count_q) ? tk_pkg::ST_IDLE : tk_pkg::ST_OUT_RD;
      default: state_d = tk_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = cand_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;
    case (state_q)
      tk_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (c.action)
            tk_pkg::ACT_CLEAR: count_d = '0;
            tk_pkg::ACT_OFFER: begin
              rd_en = 1'b1;
              idx_d = (count_q >= limit) ? CntW'(1) : count_q;
            end
            tk_pkg::ACT_READ: begin
              idx_d = '0;
              if (count_q == '0) begin
                res_d = '0;
                res_d.last = 1'b1;
                res_valid_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tk_pkg::ST_SH_RD: begin
        if (idx_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[IdxW-1:0];
        end else begin
          count_d = count_q - 1'b1;
          idx_d   = count_q - 1'b1;
        end
      end
      tk_pkg::ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = IdxW'(idx_q - 1'b1);
        wr_data = rd_data_q;
        idx_d   = idx_q + 1'b1;
      end
      tk_pkg::ST_INS_RD: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(idx_q - 1'b1);
        end
      end
      tk_pkg::ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IdxW-1:0];
        if (tk_pkg::ahead_of(rd_data_q, cand_q)) begin
          count_d = count_q + 1'b1;
        end else begin
          wr_data = rd_data_q;
          idx_d   = idx_q - 1'b1;
        end
      end
      tk_pkg::ST_OUT_RD: begin
        if (out_free) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[IdxW-1:0];
        end
      end
      tk_pkg::ST_OUT_WR: begin
        res_d.entry_valid      = 1'b1;
        res_d.last             = (idx_q + 1'b1 == count_q);
        res_d.out_priority     = rd_data_q.prio_b ^ 16'h8000;
        res_d.out_shader_id    = rd_data_q.shader;
        res_d.out_entity_id    = rd_data_q.entity;
        res_d.out_radius       = rd_data_q.rad;
        res_d.out_inner_radius = rd_data_q.inner;
        res_d.out_falloff      = rd_data_q.fall;
        res_d.out_strength     = rd_data_q.str;
        res_d.out_spin         = rd_data_q.spin;
        res_d.out_shape        = rd_data_q.shape;
        res_d.list_count       = 4'(count_q);
        res_valid_d            = 1'b1;
        idx_d                  = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) cand_q <= cand_d;
    res_q <= res_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tk_pkg::ST_IDLE;
      count_q     <= '0;
      budget_q    <= tk_pkg::BUDGET_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) budget_q <= cfg_wdata_i;
    end
  end

endmodule

[hdl/tk_checker.sv]
// ----------------------------------------------------------------------------
// tk_checker
// Port-level checks on the result channel of the sorted list.
// ----------------------------------------------------------------------------
module tk_checker #(
  parameter int CAPACITY = tk_pkg::CAPACITY_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         res_valid,
  input logic         res_ready,
  input tk_pkg::res_t res_data
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result item changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_data.entry_valid |-> res_data.last && res_data.list_count == 4'd0)
    else $error("empty read out item malformed");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.entry_valid |-> res_data.list_count != 4'd0 &&
      32'(res_data.list_count) <= CAPACITY)
    else $error("entry item with bad list count");

  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && res_data.entry_valid && !res_data.last |=>
      !res_valid || (res_data.entry_valid && res_data.list_count == $past(res_data.list_count)))
    else $error("read out broken before last item");

endmodule

bind bounded_top_k_sorted_insert tk_checker #(.CAPACITY(CAPACITY)) u_tk_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_data  (res_o.data)
);

[dv/tb_bounded_top_k_sorted_insert.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_top_k_sorted_insert
// Self-checking bench for the bounded top-k sorted insertion list: a local
// list model predicts each read out, a driver and monitor apply random gaps
// and stalls, and the budget is swept across phases between idle points.
// ----------------------------------------------------------------------------
module tb_bounded_top_k_sorted_insert;

  localparam int CAP = tk_pkg::CAPACITY_DEF;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  tk_stream_if #(.T(tk_pkg::cand_t)) cand_if ();
  tk_stream_if #(.T(tk_pkg::res_t))  res_if ();

  bounded_top_k_sorted_insert DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cand_i     (cand_if.sink),
    .res_o      (res_if.source)
  );

  typedef struct {
    logic [47:0]  key;
    logic [31:0]  ent;
    tk_pkg::res_t r;
  } lens_slot_t;

  lens_slot_t list_m[CAP];
  int unsigned held_m;
  logic [3:0]  budget_m;

  tk_pkg::cand_t pending_q[$];
  tk_pkg::res_t  expected_q[$];
  int    mismatches;
  int    results_seen;
  bit    sink_hold;
  int    hold_cycles = 0;
  int    send_gap;
  int    recv_gap;

  function automatic void add_pending(input tk_pkg::cand_t c);
    pending_q.insert(pending_q.size(), c);
  endfunction

  function automatic void add_expected(input tk_pkg::res_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic bit sorts_first(logic [47:0] ka, logic [31:0] ea,
                                     logic [47:0] kb, logic [31:0] eb);
    return {ka, ea} < {kb, eb};
  endfunction

  task automatic predict_list(input tk_pkg::cand_t c);
    int unsigned  limit;
    int unsigned  pos;
    int           rad;
    int           inner;
    int           fall;
    int           str;
    lens_slot_t   s;
    tk_pkg::res_t e;
    limit = (budget_m > CAP) ? CAP : budget_m;
    case (c.action)
      tk_pkg::ACT_CLEAR: held_m = 0;
      tk_pkg::ACT_READ: begin
        if (held_m == 0) begin
          e = '0;
          e.last = 1'b1;
          add_expected(e);
        end else begin
          for (int k = 0; k < held_m; k++) begin
            e = list_m[k].r;
            e.last = (k + 1 == held_m);
            e.list_count = held_m[3:0];
            add_expected(e);
          end
        end
      end
      tk_pkg::ACT_OFFER: begin
        rad = c.radius;
        if (c.enabled && c.shader_valid && limit != 0 && rad > 0) begin
          inner = c.inner_radius;
          if (inner < 0) inner = 0;
          if (inner > rad) inner = rad;
          fall = c.falloff;
          if (fall < 0) fall = 0;
          if (fall > 16384) fall = 16384;
          str = c.strength;
          if (str < 0) str = 0;
          s.key = {c.priority_req ^ 16'h8000, c.shader_id};
          s.ent = c.entity_id;
          s.r = '0;
          s.r.entry_valid = 1'b1;
          s.r.out_priority = c.priority_req;
          s.r.out_shader_id = c.shader_id;
          s.r.out_entity_id = c.entity_id;
          s.r.out_radius = rad[14:0];
          s.r.out_inner_radius = inner[14:0];
          s.r.out_falloff = fall[14:0];
          s.r.out_strength = str[14:0];
          s.r.out_spin = c.spin;
          s.r.out_shape = c.shape;
          if (held_m >= limit) begin
            if (sorts_first(list_m[0].key, list_m[0].ent, s.key, s.ent)) begin
              for (int i = 1; i < held_m; i++) list_m[i-1] = list_m[i];
              held_m--;
            end else begin
              return;
            end
          end
          pos = 0;
          while (pos < held_m && sorts_first(list_m[pos].key, list_m[pos].ent,
                                             s.key, s.ent)) pos++;
          for (int i = held_m; i > pos; i--) list_m[i] = list_m[i-1];
          list_m[pos] = s;
          held_m++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic tk_pkg::cand_t make_lens(input bit wellformed, input int prio_span);
    tk_pkg::cand_t c;
    c.action = tk_pkg::ACT_OFFER;
    c.enabled = wellformed ? 1'b1 : 1'($urandom);
    c.shader_valid = wellformed ? 1'b1 : 1'($urandom);
    c.priority_req = (prio_span > 0) ? 16'($urandom_range(0, prio_span)) - 16'(prio_span / 2)
                                     : 16'($urandom);
    c.shader_id = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
    c.entity_id = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
    c.radius = wellformed ? 16'($urandom_range(1, 32767)) : 16'($urandom);
    c.inner_radius = 16'($urandom);
    c.falloff = 16'($urandom);
    c.strength = 16'($urandom);
    c.spin = 16'($urandom);
    c.shape = 2'($urandom);
    return c;
  endfunction

  function automatic tk_pkg::cand_t make_action(input logic [1:0] act);
    tk_pkg::cand_t c;
    c = make_lens(1'b0, 0);
    c.action = act;
    return c;
  endfunction

  task automatic write_budget(input logic [3:0] b);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    budget_m = b;
  endtask

  task automatic drain_and_settle();
    wait (pending_q.size() == 0 && !cand_if.valid);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // count the cycles of the receiver hold
  always @(posedge clk_i) begin
    if (sink_hold) hold_cycles <= hold_cycles + 1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_if.valid <= 1'b0;
      cand_if.data  <= '0;
      send_gap      <= 0;
    end else begin
      if (cand_if.valid && cand_if.ready) begin
        predict_list(cand_if.data);
      end
      if (cand_if.valid && !cand_if.ready) begin
      end else if (send_gap > 0) begin
        cand_if.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
        cand_if.valid <= 1'b1;
        cand_if.data  <= pending_q.pop_front();
        send_gap      <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else begin
        cand_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %p", res_if.data);
        end else if (res_if.data !== expected_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_q[0], res_if.data);
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      if (sink_hold) begin
        res_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        res_if.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else begin
        res_if.ready <= 1'b1;
        if (res_if.valid && res_if.ready)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    tk_pkg::cand_t c;
    logic [3:0] budgets[6];
    budgets     = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    sink_hold   = 1'b0;
    mismatches  = 0;
    results_seen = 0;
    held_m      = 0;
    budget_m    = tk_pkg::BUDGET_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    add_pending(make_action(tk_pkg::ACT_READ));
    c = make_lens(1'b1, 0);
    c.priority_req = 16'sh7fff; c.shader_id = '1; c.entity_id = '1;
    c.radius = 16'sh7fff; c.inner_radius = 16'sh8000; c.falloff = 16'sh7fff;
    c.strength = 16'sh8000; c.spin = 16'sh8000; c.shape = 2'd3;
    add_pending(c);
    c = make_lens(1'b1, 0);
    c.priority_req = 16'sh8000; c.shader_id = '0; c.entity_id = '0;
    c.radius = 16'sd1; c.inner_radius = 16'sh7fff; c.falloff = 16'sh8000;
    c.strength = 16'sh7fff; c.spin = 16'sh7fff; c.shape = 2'd0;
    add_pending(c);
    c.entity_id = 32'd5;
    add_pending(c);
    c.entity_id = 32'd5;
    c.spin = 16'sd7;
    add_pending(c);
    c = make_lens(1'b1, 0); c.enabled = 1'b0; add_pending(c);
    c = make_lens(1'b1, 0); c.shader_valid = 1'b0; add_pending(c);
    c = make_lens(1'b1, 0); c.radius = 16'sd0; add_pending(c);
    c = make_lens(1'b1, 0); c.radius = 16'sh8000; add_pending(c);
    add_pending(make_action(tk_pkg::ACT_RSVD));
    add_pending(make_action(tk_pkg::ACT_READ));
    for (int i = 0; i < 8; i++) add_pending(make_lens(1'b1, 40));
    add_pending(make_action(tk_pkg::ACT_READ));
    add_pending(make_action(tk_pkg::ACT_CLEAR));
    add_pending(make_action(tk_pkg::ACT_READ));
    drain_and_settle();

    // hold the receiver while the sender fills the block
    sink_hold = 1'b1;
    for (int i = 0; i < 6; i++) begin
      add_pending(make_lens(1'b1, 100));
      add_pending(make_action(tk_pkg::ACT_READ));
    end
    wait (hold_cycles >= 400);
    sink_hold = 1'b0;
    drain_and_settle();

    // sweep budget settings, including ones below the held count
    foreach (budgets[p]) begin
      write_budget(budgets[p]);
      for (int i = 0; i < 60; i++) begin
        case ($urandom_range(0, 19))
          0: add_pending(make_action(tk_pkg::ACT_CLEAR));
          1: add_pending(make_action(tk_pkg::ACT_RSVD));
          2, 3, 4: add_pending(make_action(tk_pkg::ACT_READ));
          5, 6: add_pending(make_lens(1'b0, 0));
          default: add_pending(make_lens(1'b1, ($urandom_range(0, 1)) ? 20 : 0));
        endcase
      end
      add_pending(make_action(tk_pkg::ACT_READ));
      drain_and_settle();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Covered directed extremes, a long output stall, and %0d result items",
               results_seen);
      $display("across six budget settings including zero and saturation.");
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d items still awaited", mismatches, expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
